/* src/mst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Material sort tracker package
// Shared widths, codes, reset values and the stage handoff types.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Field widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned LIMIT_W    = 11;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned STEPS_W    = 7;
  localparam int unsigned CFG_INDEX_W = 2;

  // Default ring depth for the top level.
  localparam int unsigned RING_DEPTH_DEFAULT = 64;

  // Event codes.
  typedef enum logic [OP_W-1:0] {
    OP_ENTER  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_EXIT   = 2'd2,
    OP_NONE   = 2'd3
  } mst_op_t;

  // Class codes.
  localparam logic [CLASS_W-1:0] CLS_STEEL     = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_BLACK     = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_ALUMINIUM = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_WHITE     = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN   = 3'd4;

  // Number of classes that own a sorted counter.
  localparam int unsigned CLASS_COUNTED = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ALUMINIUM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEEL     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WHITE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLACK     = 2'd3;

  // Reset values.
  localparam logic [LIMIT_W-1:0]  ALUMINIUM_RESET = 11'd200;
  localparam logic [LIMIT_W-1:0]  STEEL_RESET     = 11'd700;
  localparam logic [LIMIT_W-1:0]  WHITE_RESET     = 11'd935;
  localparam logic [LIMIT_W-1:0]  BLACK_RESET     = 11'd1024;
  localparam logic [SAMPLE_W-1:0] MIN_RESET       = 10'd1023;
  localparam logic [CLASS_W-1:0]  BUCKET_HOME     = 3'd1;

  // Stepper rotation amounts.
  localparam logic [STEPS_W-1:0] STEPS_QUARTER = 7'd50;
  localparam logic [STEPS_W-1:0] STEPS_HALF    = 7'd100;

  // Pipeline control handed to the entry stage.
  typedef struct packed {
    logic load;     // request accepted into the entry register
    logic advance;  // entry register moves into the second stage
  } mst_pipe_ctrl_t;

  // Entry stage results held for the second stage.
  typedef struct packed {
    logic               class_valid;
    logic [CLASS_W-1:0] class_code;
    logic               exit_valid;
    logic [COUNT_W-1:0] on_belt;
    logic [CLASS_W-1:0] slot_class;
  } mst_stage_t;

endpackage
`default_nettype wire

/* src/mst_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Material sort tracker channels
// Valid/ready channels for event requests and tracker results.
// ----------------------------------------------------------------------------

// Event request channel.
interface mst_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [9:0] sample;
  logic       present;

  modport source (output valid, output op, output sample, output present, input ready);
  modport sink   (input valid, input op, input sample, input present, output ready);
endinterface

// Result channel.
interface mst_result_if;
  logic        valid;
  logic        ready;
  logic        class_valid;
  logic [2:0]  class_code;
  logic        exit_valid;
  logic [6:0]  rotate_steps;
  logic        rotate_ccw;
  logic [15:0] bucket_count;
  logic [15:0] on_belt;

  modport source (output valid, output class_valid, output class_code, output exit_valid,
                  output rotate_steps, output rotate_ccw, output bucket_count,
                  output on_belt, input ready);
  modport sink   (input valid, input class_valid, input class_code, input exit_valid,
                  input rotate_steps, input rotate_ccw, input bucket_count,
                  input on_belt, output ready);
endinterface
`default_nettype wire

/* src/mst_entry_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Material sort tracker entry stage
// Holds the part counters, running minimum, thresholds and the category ring;
// classifies samples and fetches the class of an exiting part.
// ----------------------------------------------------------------------------
module mst_entry_stage import mst_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mst_pipe_ctrl_t         ctrl,
  input  logic [OP_W-1:0]        op,
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic                   present,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data,
  output mst_stage_t             stage
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CountMax = (1 << COUNT_W) - 1;
  localparam logic [AW-1:0] WRAP_SLOT = AW'(CountMax % RING_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  // Slot of (count - 1) mod 65536 mod depth, tracked incrementally.
  function automatic logic [AW-1:0] next_slot(input logic [COUNT_W-1:0] cnt_next,
                                               input logic [AW-1:0] slot);
    logic [AW-1:0] res;
    if (cnt_next == '0) begin
      res = WRAP_SLOT;
    end else if (cnt_next == COUNT_W'(1)) begin
      res = '0;
    end else if (slot == LAST_SLOT) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

  // Threshold registers.
  logic [LIMIT_W-1:0] aluminium_limit;
  logic [LIMIT_W-1:0] steel_limit;
  logic [LIMIT_W-1:0] white_limit;
  logic [LIMIT_W-1:0] black_limit;

  // Entry register.
  mst_op_t             op_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                present_q;

  // Tracker state.
  logic [SAMPLE_W-1:0] min_reading;
  logic [COUNT_W-1:0]  entered_count;
  logic [COUNT_W-1:0]  exited_count;
  logic [AW-1:0]       write_slot;
  logic [AW-1:0]       read_slot;
  logic [CLASS_W-1:0]  category_ring [RING_DEPTH];

  // Next values.
  logic [SAMPLE_W-1:0] min_reading_next;
  logic [COUNT_W-1:0]  entered_count_next;
  logic [COUNT_W-1:0]  exited_count_next;
  logic [AW-1:0]       write_slot_next;
  logic [AW-1:0]       read_slot_next;
  logic [LIMIT_W-1:0]  min_ext;
  logic [CLASS_W-1:0]  class_sel;
  logic                classify;
  mst_stage_t          stage_q;
  logic [CLASS_W-1:0]  slot_class;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      aluminium_limit <= ALUMINIUM_RESET;
      steel_limit     <= STEEL_RESET;
      white_limit     <= WHITE_RESET;
      black_limit     <= BLACK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ALUMINIUM: aluminium_limit <= cfg_data;
        CFG_STEEL:     steel_limit     <= cfg_data;
        CFG_WHITE:     white_limit     <= cfg_data;
        CFG_BLACK:     black_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry register takes the accepted request.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_q      <= mst_op_t'(op);
      sample_q  <= sample;
      present_q <= present;
    end
  end

  // Counter, pointer and minimum updates for the held request.
  always_comb begin
    entered_count_next = entered_count;
    exited_count_next  = exited_count;
    min_reading_next   = min_reading;
    case (op_q)
      OP_ENTER: begin
        entered_count_next = entered_count + 1'b1;
        min_reading_next   = MIN_RESET;
      end
      OP_SAMPLE: begin
        if (sample_q < min_reading) begin
          min_reading_next = sample_q;
        end
      end
      OP_EXIT: begin
        exited_count_next = exited_count + 1'b1;
      end
      default: ;
    endcase
    write_slot_next = (op_q == OP_ENTER) ? next_slot(entered_count_next, write_slot)
                                         : write_slot;
    read_slot_next  = (op_q == OP_EXIT) ? next_slot(exited_count_next, read_slot)
                                        : read_slot;
  end

  // Threshold ladder on the updated minimum.
  always_comb begin
    min_ext  = {1'b0, min_reading_next};
    classify = (op_q == OP_SAMPLE) && !present_q;
    if (min_ext <= aluminium_limit) begin
      class_sel = CLS_ALUMINIUM;
    end else if (min_ext <= steel_limit) begin
      class_sel = CLS_STEEL;
    end else if (min_ext <= white_limit) begin
      class_sel = CLS_WHITE;
    end else if (min_ext <= black_limit) begin
      class_sel = CLS_BLACK;
    end else begin
      class_sel = CLS_UNKNOWN;
    end
  end

  // State commits when the request moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_reading   <= MIN_RESET;
      entered_count <= '0;
      exited_count  <= '0;
      write_slot    <= WRAP_SLOT;
      read_slot     <= WRAP_SLOT;
    end else if (ctrl.advance) begin
      min_reading   <= min_reading_next;
      entered_count <= entered_count_next;
      exited_count  <= exited_count_next;
      write_slot    <= write_slot_next;
      read_slot     <= read_slot_next;
    end
  end

  // Category ring: classified parts are written, exiting parts are read.
  always_ff @(posedge clk) begin
    if (ctrl.advance && classify) begin
      category_ring[write_slot] <= class_sel;
    end
    if (ctrl.advance && (op_q == OP_EXIT)) begin
      slot_class <= category_ring[read_slot_next];
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      stage_q.class_valid <= classify;
      stage_q.class_code  <= classify ? class_sel : '0;
      stage_q.exit_valid  <= (op_q == OP_EXIT);
      stage_q.on_belt     <= entered_count_next - exited_count_next;
      stage_q.slot_class  <= '0;
    end
  end

  always_comb begin
    stage            = stage_q;
    stage.slot_class = slot_class;
  end

endmodule
`default_nettype wire

/* src/material_sort_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle while the result side is ready; the entry
// stage with its registered category ring read is followed by the sorting stage
// and the result register.
// Reset clears the counters and pipeline, restores the default thresholds and
// sends the bucket home; the category ring is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// Material sort tracker
// Tracks parts on a sorting conveyor: classification, exit counting and
// bucket rotation for each exiting part.
// ----------------------------------------------------------------------------
module material_sort_tracker_unit import mst_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  mst_event_if.sink              events,
  mst_result_if.source           results,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data
);

  // Pipeline occupancy.
  logic           entry_valid;
  logic           sort_valid;
  logic           out_valid;
  logic           out_load;
  logic           sort_free;
  logic           entry_free;
  logic           sort_move;
  mst_pipe_ctrl_t ctrl;
  mst_stage_t     stage;

  // Sorting state.
  logic [COUNT_W-1:0] sorted_counts [CLASS_COUNTED];
  logic [CLASS_W-1:0] bucket_position;

  // Sorting stage values.
  logic               counted;
  logic [COUNT_W-1:0] count_next;
  logic [3:0]         diff;
  logic [STEPS_W-1:0] steps;
  logic               ccw;

  // Result register.
  logic               out_class_valid;
  logic [CLASS_W-1:0] out_class_code;
  logic               out_exit_valid;
  logic [STEPS_W-1:0] out_steps;
  logic               out_ccw;
  logic [COUNT_W-1:0] out_bucket_count;
  logic [COUNT_W-1:0] out_on_belt;

  // Handshake flow between stages.
  always_comb begin
    out_load     = !out_valid || results.ready;
    sort_free    = !sort_valid || out_load;
    sort_move    = sort_valid && out_load;
    entry_free   = !entry_valid || sort_free;
    ctrl.load    = events.valid && entry_free;
    ctrl.advance = entry_valid && sort_free;
  end

  assign events.ready = entry_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      sort_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (entry_free) begin
        entry_valid <= events.valid;
      end
      if (sort_free) begin
        sort_valid <= entry_valid;
      end
      if (out_load) begin
        out_valid <= sort_valid;
      end
    end
  end

  mst_entry_stage #(
    .RING_DEPTH (RING_DEPTH)
  ) u_entry (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .op        (events.op),
    .sample    (events.sample),
    .present   (events.present),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage)
  );

  // Class counter and bucket rotation for an exiting part.
  always_comb begin
    counted    = stage.exit_valid && (stage.slot_class < CLASS_W'(CLASS_COUNTED));
    count_next = sorted_counts[stage.slot_class[1:0]] + 1'b1;
    diff       = {1'b0, stage.slot_class} - {1'b0, bucket_position};
    steps      = '0;
    ccw        = 1'b0;
    case (diff)
      4'sd1, -4'sd3: steps = STEPS_QUARTER;
      -4'sd1, 4'sd3: begin
        steps = STEPS_QUARTER;
        ccw   = 1'b1;
      end
      4'sd2, -4'sd2: steps = STEPS_HALF;
      default: ;
    endcase
    if (!stage.exit_valid) begin
      steps = '0;
      ccw   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASS_COUNTED; i++) begin
        sorted_counts[i] <= '0;
      end
      bucket_position <= BUCKET_HOME;
    end else if (sort_move && stage.exit_valid) begin
      if (counted) begin
        sorted_counts[stage.slot_class[1:0]] <= count_next;
      end
      bucket_position <= stage.slot_class;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (sort_move) begin
      out_class_valid  <= stage.class_valid;
      out_class_code   <= stage.class_code;
      out_exit_valid   <= stage.exit_valid;
      out_steps        <= steps;
      out_ccw          <= ccw;
      out_bucket_count <= counted ? count_next : '0;
      out_on_belt      <= stage.on_belt;
    end
  end

  assign results.valid        = out_valid;
  assign results.class_valid  = out_class_valid;
  assign results.class_code   = out_class_code;
  assign results.exit_valid   = out_exit_valid;
  assign results.rotate_steps = out_steps;
  assign results.rotate_ccw   = out_ccw;
  assign results.bucket_count = out_bucket_count;
  assign results.on_belt      = out_on_belt;

endmodule
`default_nettype wire

/* test/material_sort_tracker_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Material sort tracker testbench
// Sends conveyor events (entry, reflectance samples, exit) through the valid/
// ready request channel. A behavioral tracker of the sorter predicts each
// result, and every accepted result is compared field by field in order.
// A short scripted sequence comes first. Randomized part sequences follow
// under several threshold settings, with sender gaps, receiver stalls and
// one long receiver hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module material_sort_tracker_unit_tb;
  import mst_pkg::*;

  localparam int unsigned RING            = RING_DEPTH_DEFAULT;
  localparam int unsigned PARTS_PER_PHASE = 110;
  localparam int unsigned HOLD_CYCLES     = 60;

  typedef struct packed {
    mst_op_t             op;
    logic [SAMPLE_W-1:0] sample;
    logic                present;
  } sort_event_t;

  typedef struct packed {
    logic               class_valid;
    logic [CLASS_W-1:0] class_code;
    logic               exit_valid;
    logic [STEPS_W-1:0] rotate_steps;
    logic               rotate_ccw;
    logic [COUNT_W-1:0] bucket_count;
    logic [COUNT_W-1:0] on_belt;
  } sort_result_t;

  typedef struct packed {
    sort_event_t  ev;
    logic         typed;
    sort_result_t want;
  } script_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]     cfg_data;

  mst_event_if  ev_if ();
  mst_result_if res_if ();

  material_sort_tracker_unit #(.RING_DEPTH(RING)) dut (
    .clk       (clk),
    .rst       (rst),
    .events    (ev_if),
    .results   (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Behavioral copy of the tracker state.
  logic [LIMIT_W-1:0]  limit_q [4];
  logic [SAMPLE_W-1:0] low_reading;
  logic [COUNT_W-1:0]  parts_in;
  logic [COUNT_W-1:0]  parts_out;
  logic [CLASS_W-1:0]  slot_class [RING];
  bit                  slot_filled [RING];
  logic [COUNT_W-1:0]  class_tally [CLASS_COUNTED];
  logic [CLASS_W-1:0]  bucket_at;

  sort_result_t due_reports [$];
  script_row_t  script [$];
  int unsigned  mismatches;
  int unsigned  requests_sent;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_left;
  logic [LIMIT_W-1:0] cut0, cut1, cut2, cut3;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned ring_slot(logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0] prev;
    prev = count - 1'b1;
    return prev % RING;
  endfunction

  // Thresholds are checked in the order aluminium, steel, white, black; first match wins.
  function automatic logic [CLASS_W-1:0] grade(logic [SAMPLE_W-1:0] m);
    logic [LIMIT_W-1:0] w;
    w = {1'b0, m};
    if (w <= limit_q[CFG_ALUMINIUM]) return CLS_ALUMINIUM;
    if (w <= limit_q[CFG_STEEL]) return CLS_STEEL;
    if (w <= limit_q[CFG_WHITE]) return CLS_WHITE;
    if (w <= limit_q[CFG_BLACK]) return CLS_BLACK;
    return CLS_UNKNOWN;
  endfunction

  task automatic reset_tracker();
    limit_q[CFG_ALUMINIUM] = ALUMINIUM_RESET;
    limit_q[CFG_STEEL]     = STEEL_RESET;
    limit_q[CFG_WHITE]     = WHITE_RESET;
    limit_q[CFG_BLACK]     = BLACK_RESET;
    low_reading = MIN_RESET;
    parts_in    = '0;
    parts_out   = '0;
    bucket_at   = BUCKET_HOME;
    foreach (slot_filled[i]) begin
      slot_filled[i] = 1'b0;
      slot_class[i]  = CLS_STEEL;
    end
    foreach (class_tally[i]) class_tally[i] = '0;
  endtask

  // Applies one event to the tracker copy and returns the result it gives.
  function automatic sort_result_t track_event(sort_event_t ev);
    sort_result_t       r;
    logic [CLASS_W-1:0] cls;
    int unsigned        idx;
    int                 diff;
    r = '0;
    case (ev.op)
      OP_ENTER: begin
        parts_in    = parts_in + 1'b1;
        low_reading = MIN_RESET;
      end
      OP_SAMPLE: begin
        if (ev.sample < low_reading) low_reading = ev.sample;
        if (!ev.present) begin
          r.class_valid    = 1'b1;
          r.class_code     = grade(low_reading);
          idx              = ring_slot(parts_in);
          slot_class[idx]  = r.class_code;
          slot_filled[idx] = 1'b1;
        end
      end
      OP_EXIT: begin
        parts_out   = parts_out + 1'b1;
        cls         = slot_class[ring_slot(parts_out)];
        r.exit_valid = 1'b1;
        if (cls < CLASS_COUNTED) begin
          class_tally[cls[1:0]] = class_tally[cls[1:0]] + 1'b1;
          r.bucket_count        = class_tally[cls[1:0]];
        end
        // Shortest turn of the four-position bucket toward the new class.
        diff = int'(cls) - int'(bucket_at);
        if (diff == 1 || diff == -3) begin
          r.rotate_steps = STEPS_QUARTER;
        end else if (diff == -1 || diff == 3) begin
          r.rotate_steps = STEPS_QUARTER;
          r.rotate_ccw   = 1'b1;
        end else if (diff == 2 || diff == -2) begin
          r.rotate_steps = STEPS_HALF;
        end
        bucket_at = cls;
      end
      default: ;
    endcase
    r.on_belt = parts_in - parts_out;
    return r;
  endfunction

  // An exit may only read a ring slot that has been classified at some point.
  function automatic bit exit_ok();
    return slot_filled[ring_slot(parts_out + 1'b1)];
  endfunction

  function automatic int belt_load();
    logic signed [COUNT_W-1:0] d;
    d = parts_in - parts_out;
    return int'(d);
  endfunction

  // Reflectance that often sits right at a threshold or at a rail.
  function automatic logic [SAMPLE_W-1:0] pick_reading();
    int          v;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      v = int'(limit_q[2'($urandom_range(0, 3))]) + int'($urandom_range(0, 2)) - 1;
    end else if (roll < 40) begin
      v = $urandom_range(0, 1) ? 1023 : 0;
    end else begin
      v = $urandom_range(0, 1023);
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  function automatic script_row_t row(mst_op_t op, int sample, logic present);
    script_row_t r;
    r            = '0;
    r.ev.op      = op;
    r.ev.sample  = SAMPLE_W'(sample);
    r.ev.present = present;
    return r;
  endfunction

  function automatic script_row_t row_exp(mst_op_t op, int sample, logic present,
                                          logic cv, logic [CLASS_W-1:0] code, logic xv,
                                          logic [STEPS_W-1:0] steps, logic ccw,
                                          logic [COUNT_W-1:0] count,
                                          logic [COUNT_W-1:0] belt);
    script_row_t r;
    r                   = row(op, sample, present);
    r.typed             = 1'b1;
    r.want.class_valid  = cv;
    r.want.class_code   = code;
    r.want.exit_valid   = xv;
    r.want.rotate_steps = steps;
    r.want.rotate_ccw   = ccw;
    r.want.bucket_count = count;
    r.want.on_belt      = belt;
    return r;
  endfunction

  // Offers one request, starting and ending at a falling edge.
  task automatic send_event(input sort_event_t ev, input logic typed,
                            input sort_result_t typed_want);
    sort_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      ev_if.valid <= 1'b0;
      @(negedge clk);
    end
    ev_if.valid   <= 1'b1;
    ev_if.op      <= ev.op;
    ev_if.sample  <= ev.sample;
    ev_if.present <= ev.present;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    want = track_event(ev);
    due_reports.push_back(typed ? typed_want : want);
    if (ev.op != OP_NONE) requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(input mst_op_t op, input logic [SAMPLE_W-1:0] sample,
                            input logic present);
    sort_event_t ev;
    ev.op      = op;
    ev.sample  = sample;
    ev.present = present;
    send_event(ev, 1'b0, '0);
  endtask

  // Drops valid and waits until every outstanding result has come back.
  task automatic settle();
    ev_if.valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_INDEX_W-1:0] index,
                             input logic [LIMIT_W-1:0] value);
    cfg_write      <= 1'b1;
    cfg_index      <= index;
    cfg_data       <= value;
    limit_q[index]  = value;
    @(negedge clk);
  endtask

  // Random traffic: mostly complete parts, some stray and unused events.
  task automatic run_parts(input int unsigned target);
    int unsigned         goal;
    int unsigned         n;
    logic [SAMPLE_W-1:0] base;
    goal = requests_sent + target;
    while (requests_sent < goal) begin
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 3))
          0: send_plain(OP_NONE, SAMPLE_W'($urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)));
          1: send_plain(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)));
          2: send_plain(OP_ENTER, SAMPLE_W'($urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)));
          default: begin
            if (exit_ok())
              send_plain(OP_EXIT, SAMPLE_W'($urandom_range(0, 1023)),
                         1'($urandom_range(0, 1)));
          end
        endcase
      end else begin
        base = pick_reading();
        send_plain(OP_ENTER, SAMPLE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 3);
        repeat (n) send_plain(OP_SAMPLE, SAMPLE_W'($urandom_range(base, 1023)), 1'b1);
        send_plain(OP_SAMPLE, base, 1'b0);
        // Sometimes the sensor reports a second time and the class is redone.
        if ($urandom_range(0, 4) == 0) send_plain(OP_SAMPLE, pick_reading(), 1'b0);
        while (belt_load() > int'($urandom_range(0, 3)) && exit_ok())
          send_plain(OP_EXIT, SAMPLE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] alu, input logic [LIMIT_W-1:0] steel,
                           input logic [LIMIT_W-1:0] white, input logic [LIMIT_W-1:0] black,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned hold);
    settle();
    write_limit(CFG_ALUMINIUM, alu);
    write_limit(CFG_STEEL, steel);
    write_limit(CFG_WHITE, white);
    write_limit(CFG_BLACK, black);
    cfg_write      <= 1'b0;
    send_idle_pct   = send_pct;
    recv_stall_pct  = recv_pct;
    hold_left       = hold;
    @(negedge clk);
    run_parts(PARTS_PER_PHASE);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side ready, with random stalls and an occasional long hold.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin : result_check
    sort_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, actual on_belt %0d",
                 $time, res_if.on_belt);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        compare_field("class_valid", 32'(want.class_valid), 32'(res_if.class_valid));
        compare_field("class_code", 32'(want.class_code), 32'(res_if.class_code));
        compare_field("exit_valid", 32'(want.exit_valid), 32'(res_if.exit_valid));
        compare_field("rotate_steps", 32'(want.rotate_steps), 32'(res_if.rotate_steps));
        compare_field("rotate_ccw", 32'(want.rotate_ccw), 32'(res_if.rotate_ccw));
        compare_field("bucket_count", 32'(want.bucket_count), 32'(res_if.bucket_count));
        compare_field("on_belt", 32'(want.on_belt), 32'(res_if.on_belt));
      end
    end
  end

  // Stimulus.
  initial begin
    rst            = 1'b1;
    ev_if.valid    = 1'b0;
    ev_if.op       = OP_NONE;
    ev_if.sample   = '0;
    ev_if.present  = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = CFG_ALUMINIUM;
    cfg_data       = '0;
    mismatches     = 0;
    requests_sent  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    reset_tracker();

    // Scripted sequence under the reset thresholds, bucket starting at home.
    script.push_back(row_exp(OP_NONE, 1023, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 16'd0, 16'd0));
    script.push_back(row_exp(OP_ENTER, 0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 16'd0, 16'd1));
    script.push_back(row_exp(OP_SAMPLE, 0, 1'b0, 1'b1, CLS_ALUMINIUM, 1'b0, '0, 1'b0,
                             16'd0, 16'd1));
    script.push_back(row_exp(OP_EXIT, 0, 1'b0, 1'b0, '0, 1'b1, STEPS_QUARTER, 1'b0,
                             16'd1, 16'd0));
    script.push_back(row_exp(OP_ENTER, 0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 16'd0, 16'd1));
    script.push_back(row_exp(OP_SAMPLE, 1023, 1'b0, 1'b1, CLS_BLACK, 1'b0, '0, 1'b0,
                             16'd0, 16'd1));
    // Repeated classification of one part, ending just at the white limit.
    script.push_back(row(OP_SAMPLE, 936, 1'b0));
    script.push_back(row(OP_SAMPLE, 935, 1'b0));
    script.push_back(row(OP_EXIT, 0, 1'b0));
    script.push_back(row(OP_ENTER, 0, 1'b0));
    script.push_back(row(OP_SAMPLE, 700, 1'b0));
    script.push_back(row(OP_EXIT, 0, 1'b0));
    script.push_back(row(OP_ENTER, 0, 1'b0));
    script.push_back(row(OP_SAMPLE, 701, 1'b1));
    script.push_back(row(OP_SAMPLE, 1000, 1'b0));
    script.push_back(row(OP_EXIT, 0, 1'b0));
    script.push_back(row(OP_ENTER, 0, 1'b0));
    script.push_back(row(OP_SAMPLE, 200, 1'b0));
    script.push_back(row(OP_EXIT, 0, 1'b0));
    script.push_back(row(OP_ENTER, 0, 1'b0));
    script.push_back(row(OP_SAMPLE, 512, 1'b0));
    script.push_back(row(OP_EXIT, 0, 1'b0));
    script.push_back(row(OP_ENTER, 0, 1'b0));
    script.push_back(row(OP_SAMPLE, 0, 1'b0));
    script.push_back(row(OP_EXIT, 0, 1'b0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);

    // Random limits, sorted so that every class can occur.
    cut0 = LIMIT_W'($urandom_range(0, 400));
    cut1 = cut0 + LIMIT_W'($urandom_range(0, 300));
    cut2 = cut1 + LIMIT_W'($urandom_range(0, 200));
    cut3 = cut2 + LIMIT_W'($urandom_range(0, 124));

    run_phase(ALUMINIUM_RESET, STEEL_RESET, WHITE_RESET, BLACK_RESET, 0, 0, 0);
    run_phase(11'd0, 11'd0, 11'd0, 11'd0, 45, 0, 0);
    run_phase(11'd1024, 11'd1024, 11'd1024, 11'd1024, 0, 45, 0);
    run_phase(cut0, cut1, cut2, cut3, 30, 30, 0);
    // Receiver held off while requests keep coming, so the input backs up.
    run_phase(LIMIT_W'($urandom_range(0, 1024)), LIMIT_W'($urandom_range(0, 1024)),
              LIMIT_W'($urandom_range(0, 1024)), LIMIT_W'($urandom_range(0, 1024)),
              0, 0, HOLD_CYCLES);
    run_phase(11'd100, 11'd400, 11'd800, 11'd1000, 30, 45, 0);

    settle();
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
